/* src/ybf_pkg.sv */
`default_nettype none

package ybf_pkg;

   // frame size limits
   localparam int unsigned MAX_PAIRS_PER_LINE = 2048;
   localparam int unsigned MAX_LINES          = 4096;

   localparam int unsigned PAIRS_W = 12;   // holds 1..MAX_PAIRS_PER_LINE
   localparam int unsigned LINES_W = 13;   // holds 1..MAX_LINES
   localparam int unsigned COL_W   = 11;
   localparam int unsigned ROW_W   = 12;
   localparam int unsigned INDEX_W = 23;
   localparam int unsigned CSR_W   = 13;

   // register map
   typedef enum logic [0:0] {
      CSR_PAIRS_PER_LINE  = 1'b0,
      CSR_LINES_PER_FRAME = 1'b1
   } csr_index_type;

   // bt.601 full range coefficients in q16
   localparam logic signed [17:0] Q_RV = 18'sd91881;
   localparam logic signed [17:0] Q_GU = 18'sd22554;
   localparam logic signed [17:0] Q_GV = 18'sd46802;
   localparam logic signed [17:0] Q_BU = 18'sd116130;

   localparam int unsigned ACC_W = 27;

   typedef struct packed {
      logic [7:0] blue_first;
      logic [7:0] green_first;
      logic [7:0] red_first;
      logic [7:0] blue_second;
      logic [7:0] green_second;
      logic [7:0] red_second;
   } bgr_pair_type;

   // raster position of one transaction
   typedef struct packed {
      logic [COL_W-1:0]   column;
      logic [ROW_W-1:0]   flipped_row;
      logic [PAIRS_W-1:0] pairs;
      logic               frame_end;
   } raster_pos_type;

   // floor of acc / 65536, clamped to 0..255
   function automatic logic [7:0] floor_clamp(input logic signed [ACC_W-1:0] acc);
      logic [7:0] result;
      if (acc[ACC_W-1]) begin
         result = 8'd0;
      end else if (|acc[ACC_W-2:24]) begin
         result = 8'd255;
      end else begin
         result = acc[23:16];
      end
      return result;
   endfunction

endpackage

`default_nettype wire

/* src/ybf_color.sv */
`default_nettype none

module ybf_color (
   input  wire logic [7:0]              luma_first,
   input  wire logic [7:0]              chroma_blue,
   input  wire logic [7:0]              luma_second,
   input  wire logic [7:0]              chroma_red,
   output ybf_pkg::bgr_pair_type        pixels
);
   import ybf_pkg::*;

   logic signed [8:0]       u_val;
   logic signed [8:0]       v_val;
   logic signed [ACC_W-1:0] delta_b;
   logic signed [ACC_W-1:0] delta_g;
   logic signed [ACC_W-1:0] delta_r;
   logic signed [ACC_W-1:0] base_first;
   logic signed [ACC_W-1:0] base_second;

   // remove chroma offset
   assign u_val = $signed({1'b0, chroma_blue}) - 9'sd128;
   assign v_val = $signed({1'b0, chroma_red}) - 9'sd128;

   // chroma terms shared by both pixels
   assign delta_b = u_val * Q_BU;
   assign delta_r = v_val * Q_RV;
   assign delta_g = -(u_val * Q_GU) - (v_val * Q_GV);

   assign base_first  = $signed({3'b000, luma_first, 16'h0000});
   assign base_second = $signed({3'b000, luma_second, 16'h0000});

   always_comb begin
      pixels.blue_first   = floor_clamp(base_first + delta_b);
      pixels.green_first  = floor_clamp(base_first + delta_g);
      pixels.red_first    = floor_clamp(base_first + delta_r);
      pixels.blue_second  = floor_clamp(base_second + delta_b);
      pixels.green_second = floor_clamp(base_second + delta_g);
      pixels.red_second   = floor_clamp(base_second + delta_r);
   end

endmodule

`default_nettype wire

/* src/ybf_raster.sv */
`default_nettype none

module ybf_raster (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_write_en,
   input  wire logic [0:0]                 csr_index,
   input  wire logic [ybf_pkg::CSR_W-1:0]  csr_wdata,
   input  wire logic                       advance,
   output ybf_pkg::raster_pos_type         pos
);
   import ybf_pkg::*;

   logic [PAIRS_W-1:0] pairs_cfg_ff;
   logic [LINES_W-1:0] lines_cfg_ff;
   logic [COL_W-1:0]   column_ff;
   logic [COL_W-1:0]   column_in;
   logic [ROW_W-1:0]   row_ff;
   logic [ROW_W-1:0]   row_in;

   logic [PAIRS_W-1:0] pairs_eff;
   logic [LINES_W-1:0] lines_eff;
   logic [COL_W-1:0]   column_eff;
   logic [ROW_W-1:0]   row_eff;
   logic               last_col;
   logic               last_row;
   logic [LINES_W-1:0] flipped_wide;

   // zero acts as one, oversize saturates at the limit
   always_comb begin
      if (pairs_cfg_ff == '0) begin
         pairs_eff = PAIRS_W'(1);
      end else if (pairs_cfg_ff > PAIRS_W'(MAX_PAIRS_PER_LINE)) begin
         pairs_eff = PAIRS_W'(MAX_PAIRS_PER_LINE);
      end else begin
         pairs_eff = pairs_cfg_ff;
      end
      if (lines_cfg_ff == '0) begin
         lines_eff = LINES_W'(1);
      end else if (lines_cfg_ff > LINES_W'(MAX_LINES)) begin
         lines_eff = LINES_W'(MAX_LINES);
      end else begin
         lines_eff = lines_cfg_ff;
      end
   end

   // counters left beyond a shrunken frame restart at zero
   assign column_eff = ({1'b0, column_ff} >= pairs_eff) ? '0 : column_ff;
   assign row_eff    = ({1'b0, row_ff} >= lines_eff) ? '0 : row_ff;

   assign last_col = (({1'b0, column_eff} + PAIRS_W'(1)) == pairs_eff);
   assign last_row = (({1'b0, row_eff} + LINES_W'(1)) == lines_eff);

   assign flipped_wide = lines_eff - LINES_W'(1) - {1'b0, row_eff};

   always_comb begin
      pos.column      = column_eff;
      pos.flipped_row = flipped_wide[ROW_W-1:0];
      pos.pairs       = pairs_eff;
      pos.frame_end   = last_col && last_row;
   end

   always_comb begin
      if (last_col) begin
         column_in = '0;
         row_in    = last_row ? '0 : row_eff + ROW_W'(1);
      end else begin
         column_in = column_eff + COL_W'(1);
         row_in    = row_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pairs_cfg_ff <= PAIRS_W'(320);
         lines_cfg_ff <= LINES_W'(480);
         column_ff    <= '0;
         row_ff       <= '0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_PAIRS_PER_LINE:  pairs_cfg_ff <= csr_wdata[PAIRS_W-1:0];
               CSR_LINES_PER_FRAME: lines_cfg_ff <= csr_wdata[LINES_W-1:0];
               default: ;
            endcase
         end
         if (advance) begin
            column_ff <= column_in;
            row_ff    <= row_in;
         end
      end
   end

endmodule

`default_nettype wire

/* src/yuyv_to_bgr_flip_converter.sv */
`default_nettype none

// yuyv 4:2:2 macropixel to bgr888 pixel pair, with a bottom-up raster slot
//
// request channel: one transaction per yuyv macropixel (two lumas, shared u/v),
//   taken at a clock edge with req_valid high and req_stall low
// response channel: six clamped 8-bit colors, the pair slot in the vertically
//   flipped frame and frame_end on the last macropixel, presented with
//   rsp_valid and taken when rsp_stall is low
// config port: csr_write_en with csr_index 0 (pairs per line) or 1 (lines per
//   frame); write only while no transaction is in flight
// stages: an input register then a result register; the color
//   multiplies and the slot multiply sit between the two
// throughput: one transaction per cycle while rsp_stall is low, set by the
//   single pass between the two registers
// stall: a full result register holds while rsp_stall is high; an empty input
//   register still takes one more transaction, and once both registers
//   are full req_stall follows rsp_stall in the same cycle
// reset: both stages empty, column and row counters at zero, frame size
//   back to 320 pairs by 480 lines
module yuyv_to_bgr_flip_converter (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          csr_write_en,
   input  wire logic [0:0]                    csr_index,
   input  wire logic [ybf_pkg::CSR_W-1:0]     csr_wdata,

   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic [7:0]                    req_luma_first,
   input  wire logic [7:0]                    req_chroma_blue,
   input  wire logic [7:0]                    req_luma_second,
   input  wire logic [7:0]                    req_chroma_red,

   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic [7:0]                    rsp_blue_first,
   output      logic [7:0]                    rsp_green_first,
   output      logic [7:0]                    rsp_red_first,
   output      logic [7:0]                    rsp_blue_second,
   output      logic [7:0]                    rsp_green_second,
   output      logic [7:0]                    rsp_red_second,
   output      logic [ybf_pkg::INDEX_W-1:0]   rsp_pair_index,
   output      logic                          rsp_frame_end
);
   import ybf_pkg::*;

   // input stage
   logic           in_valid_ff;
   logic [7:0]     luma_first_ff;
   logic [7:0]     chroma_blue_ff;
   logic [7:0]     luma_second_ff;
   logic [7:0]     chroma_red_ff;
   raster_pos_type pos_ff;

   // result stage
   logic               out_valid_ff;
   bgr_pair_type       pixels_ff;
   logic [INDEX_W-1:0] pair_index_ff;
   logic               frame_end_ff;

   logic               req_take;
   logic               out_load;
   logic               in_load;
   raster_pos_type     pos_now;
   bgr_pair_type       pixels_now;
   logic [PAIRS_W+ROW_W-1:0] slot_product;
   logic [PAIRS_W+ROW_W-1:0] slot_sum;

   // result register frees when empty or being taken
   assign out_load  = !out_valid_ff || !rsp_stall;
   // input register frees when empty or moving on
   assign in_load   = !in_valid_ff || out_load;
   assign req_stall = !in_load;
   assign req_take  = req_valid && in_load;

   // counters step once per accepted transaction
   ybf_raster u_raster (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .advance      (req_take),
      .pos          (pos_now)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_load) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         luma_first_ff  <= req_luma_first;
         chroma_blue_ff <= req_chroma_blue;
         luma_second_ff <= req_luma_second;
         chroma_red_ff  <= req_chroma_red;
         pos_ff         <= pos_now;
      end
   end

   // color conversion from the input register
   ybf_color u_color (
      .luma_first  (luma_first_ff),
      .chroma_blue (chroma_blue_ff),
      .luma_second (luma_second_ff),
      .chroma_red  (chroma_red_ff),
      .pixels      (pixels_now)
   );

   // slot in the flipped raster: flipped_row * pairs + column
   assign slot_product = pos_ff.flipped_row * pos_ff.pairs;
   assign slot_sum     = slot_product + (PAIRS_W+ROW_W)'(pos_ff.column);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && in_valid_ff) begin
         pixels_ff     <= pixels_now;
         pair_index_ff <= slot_sum[INDEX_W-1:0];
         frame_end_ff  <= pos_ff.frame_end;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_blue_first   = pixels_ff.blue_first;
   assign rsp_green_first  = pixels_ff.green_first;
   assign rsp_red_first    = pixels_ff.red_first;
   assign rsp_blue_second  = pixels_ff.blue_second;
   assign rsp_green_second = pixels_ff.green_second;
   assign rsp_red_second   = pixels_ff.red_second;
   assign rsp_pair_index   = pair_index_ff;
   assign rsp_frame_end    = frame_end_ff;

endmodule

`default_nettype wire
